FILE: src/aabb_collision_resolve_unit_assert.svh
// ----------------------------------------------------------------------------
// AABB collision resolve unit: assertion macros
// Shared concurrent assertion forms, clocked on clk; one is quiet while in reset, one checks through it.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLISION_RESOLVE_UNIT_ASSERT_SVH
`define AABB_COLLISION_RESOLVE_UNIT_ASSERT_SVH

// Property checked at every rising edge of clk outside of reset.
`define AABB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge of clk, reset included.
`define AABB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/aabb_pkg.sv
// ----------------------------------------------------------------------------
// AABB collision resolve package
// Types and constants shared by the front end, queue, back end and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

    localparam int COORD_W           = 32;
    localparam int MARGIN_W          = 30;
    localparam int MODE_W            = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int MAX_OBSTACLES_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Input stream carries nine coordinates, output stream three plus two flags.
    localparam int S_TDATA_W = 9 * COORD_W;
    localparam int M_FIELD_W = 3 * COORD_W + 2;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Mode codes as they arrive on the input stream.
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESOLVE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MAX_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MAX_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MAX_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_MARGIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_MARGIN = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MARGIN_W-1:0]       margin_t;

    // Operation after classification in the front end.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_RESOLVE,
        OP_NOP
    } op_t;

    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
    } box_t;

    typedef struct packed {
        op_t    op;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        box_t   box;
    } item_t;

    typedef struct packed {
        box_t    outer;
        margin_t outer_margin;
        margin_t inner_margin;
    } cfg_t;

    typedef struct packed {
        coord_t new_x;
        coord_t new_y;
        coord_t new_z;
        logic   collided;
        logic   table_full;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_BORDER,
        B_CLAMP,
        B_WALK,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: src/aabb_front.sv
// ----------------------------------------------------------------------------
// AABB front end
// Takes requests off the input stream, classifies the mode and holds the
// request in one register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_front
    import aabb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // pos_x, pos_y, pos_z, obstacle_min_x/y/z,
                                                 // obstacle_max_x/y/z
    input  wire logic [MODE_W-1:0]    s_tuser,   // mode
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output item_t                     push_item
);

    item_t item_reg;
    item_t item_next;
    logic  valid_reg;
    logic  take;

    assign s_tready   = !valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        item_next.pos_x      = s_tdata[0*COORD_W +: COORD_W];
        item_next.pos_y      = s_tdata[1*COORD_W +: COORD_W];
        item_next.pos_z      = s_tdata[2*COORD_W +: COORD_W];
        item_next.box.lo_x   = s_tdata[3*COORD_W +: COORD_W];
        item_next.box.lo_y   = s_tdata[4*COORD_W +: COORD_W];
        item_next.box.lo_z   = s_tdata[5*COORD_W +: COORD_W];
        item_next.box.hi_x   = s_tdata[6*COORD_W +: COORD_W];
        item_next.box.hi_y   = s_tdata[7*COORD_W +: COORD_W];
        item_next.box.hi_z   = s_tdata[8*COORD_W +: COORD_W];
        unique case (s_tuser)
            MODE_CLEAR:   item_next.op = OP_CLEAR;
            MODE_APPEND:  item_next.op = OP_APPEND;
            MODE_RESOLVE: item_next.op = OP_RESOLVE;
            default:      item_next.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/aabb_queue.sv
// ----------------------------------------------------------------------------
// AABB request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_queue
    import aabb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    item_t            entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/aabb_back.sv
// ----------------------------------------------------------------------------
// AABB back end
// Executes table operations and resolves points: outer clamp, then a walk
// over the obstacle memory, one obstacle per cycle through a short pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_back
    import aabb_pkg::*;
#(
    parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire item_t pop_item,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output result_t    m_result
);

    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBSTACLES);

    // Exact sum or difference in one extra bit, then saturation to 32 bits.
    function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
        if (v[COORD_W] != v[COORD_W-1])
        begin
            return v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic coord_t sat_add(input coord_t a, input margin_t m);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {{(COORD_W+1-MARGIN_W){1'b0}}, m};
        return sat_coord(s);
    endfunction

    function automatic coord_t sat_sub(input coord_t a, input margin_t m);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} - {{(COORD_W+1-MARGIN_W){1'b0}}, m};
        return sat_coord(s);
    endfunction

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_v_reg;
    logic             g_v_reg;
    logic             out_valid_reg;
    box_t             box_mem [MAX_OBSTACLES];
    box_t             rd_data_reg;
    box_t             grown_reg;
    box_t             border_reg;
    coord_t           px_reg;
    coord_t           py_reg;
    coord_t           pz_reg;
    logic             coll_reg;
    logic             full_reg;
    result_t          out_reg;

    logic             pop_fire;
    logic             mem_we;
    logic             rd_issue;
    logic             walk_done;
    logic             load_out;

    coord_t           cx1;
    coord_t           cx;
    coord_t           cy1;
    coord_t           cy;
    coord_t           cz1;
    coord_t           cz;
    logic             clamp_coll;

    logic             in_box;
    logic signed [COORD_W:0] dxl;
    logic signed [COORD_W:0] dzl;
    logic signed [COORD_W:0] dxh;
    logic signed [COORD_W:0] dzh;
    coord_t           wx;
    coord_t           wz;

    assign pop_fire  = pop_valid && pop_ready;
    assign mem_we    = pop_fire && (pop_item.op == OP_APPEND) && (count_reg != CNT_MAX);
    assign rd_issue  = (state_reg == B_WALK) && (rd_idx_reg < count_reg);
    assign walk_done = (state_reg == B_WALK) && !rd_issue && !rd_v_reg && !g_v_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;

    // Outer clamp; the min test sees the value left by the max test.
    always_comb
    begin
        cx1 = (px_reg > border_reg.hi_x) ? border_reg.hi_x : px_reg;
        cx  = (cx1 < border_reg.lo_x) ? border_reg.lo_x : cx1;
        cy1 = (py_reg > border_reg.hi_y) ? border_reg.hi_y : py_reg;
        cy  = (cy1 < border_reg.lo_y) ? border_reg.lo_y : cy1;
        cz1 = (pz_reg > border_reg.hi_z) ? border_reg.hi_z : pz_reg;
        cz  = (cz1 < border_reg.lo_z) ? border_reg.lo_z : cz1;
        clamp_coll = (px_reg > border_reg.hi_x) || (cx1 < border_reg.lo_x)
                  || (pz_reg > border_reg.hi_z) || (cz1 < border_reg.lo_z);
    end

    // Push out of one grown obstacle toward the nearest x or z face; any tie goes to the high z face.
    always_comb
    begin
        in_box = (px_reg < grown_reg.hi_x) && (px_reg > grown_reg.lo_x)
              && (py_reg < grown_reg.hi_y) && (py_reg > grown_reg.lo_y)
              && (pz_reg < grown_reg.hi_z) && (pz_reg > grown_reg.lo_z);
        dxl = {px_reg[COORD_W-1], px_reg} - {grown_reg.lo_x[COORD_W-1], grown_reg.lo_x};
        dzl = {pz_reg[COORD_W-1], pz_reg} - {grown_reg.lo_z[COORD_W-1], grown_reg.lo_z};
        dxh = {grown_reg.hi_x[COORD_W-1], grown_reg.hi_x} - {px_reg[COORD_W-1], px_reg};
        dzh = {grown_reg.hi_z[COORD_W-1], grown_reg.hi_z} - {pz_reg[COORD_W-1], pz_reg};
        wx  = px_reg;
        wz  = pz_reg;
        priority if (dxl < dzl && dxl < dxh && dxl < dzh)
        begin
            wx = grown_reg.lo_x;
        end
        else if (dzl < dxl && dzl < dxh && dzl < dzh)
        begin
            wz = grown_reg.lo_z;
        end
        else if (dxh < dxl && dxh < dzl && dxh < dzh)
        begin
            wx = grown_reg.hi_x;
        end
        else
        begin
            wz = grown_reg.hi_z;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = (pop_item.op == OP_RESOLVE) ? B_BORDER : B_EMIT;
                end
            end
            B_BORDER:
            begin
                state_next = B_CLAMP;
            end
            B_CLAMP:
            begin
                state_next = (clamp_coll || count_reg == '0) ? B_EMIT : B_WALK;
            end
            B_WALK:
            begin
                if (walk_done)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_v_reg      <= 1'b0;
            g_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop_fire && pop_item.op == OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == B_CLAMP)
            begin
                rd_idx_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            rd_v_reg <= rd_issue;
            g_v_reg  <= rd_v_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Obstacle memory: one write port for appends, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            box_mem[count_reg[IDX_W-1:0]] <= pop_item.box;
        end
        if (rd_issue)
        begin
            rd_data_reg <= box_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            grown_reg.lo_x <= sat_sub(rd_data_reg.lo_x, cfg.inner_margin);
            grown_reg.lo_y <= sat_sub(rd_data_reg.lo_y, cfg.inner_margin);
            grown_reg.lo_z <= sat_sub(rd_data_reg.lo_z, cfg.inner_margin);
            grown_reg.hi_x <= sat_add(rd_data_reg.hi_x, cfg.inner_margin);
            grown_reg.hi_y <= sat_add(rd_data_reg.hi_y, cfg.inner_margin);
            grown_reg.hi_z <= sat_add(rd_data_reg.hi_z, cfg.inner_margin);
        end
        if (state_reg == B_BORDER)
        begin
            border_reg.lo_x <= sat_add(cfg.outer.lo_x, cfg.outer_margin);
            border_reg.lo_y <= sat_add(cfg.outer.lo_y, cfg.outer_margin);
            border_reg.lo_z <= sat_add(cfg.outer.lo_z, cfg.outer_margin);
            border_reg.hi_x <= sat_sub(cfg.outer.hi_x, cfg.outer_margin);
            border_reg.hi_y <= sat_sub(cfg.outer.hi_y, cfg.outer_margin);
            border_reg.hi_z <= sat_sub(cfg.outer.hi_z, cfg.outer_margin);
        end
        if (pop_fire)
        begin
            if (pop_item.op == OP_RESOLVE)
            begin
                px_reg <= pop_item.pos_x;
                py_reg <= pop_item.pos_y;
                pz_reg <= pop_item.pos_z;
            end
            else
            begin
                px_reg <= '0;
                py_reg <= '0;
                pz_reg <= '0;
            end
            coll_reg <= 1'b0;
            full_reg <= (pop_item.op == OP_APPEND) && (count_reg == CNT_MAX);
        end
        else if (state_reg == B_CLAMP)
        begin
            px_reg   <= cx;
            py_reg   <= cy;
            pz_reg   <= cz;
            coll_reg <= clamp_coll;
        end
        else if (state_reg == B_WALK && g_v_reg && in_box)
        begin
            px_reg   <= wx;
            pz_reg   <= wz;
            coll_reg <= 1'b1;
        end
        if (load_out)
        begin
            out_reg.new_x      <= px_reg;
            out_reg.new_y      <= py_reg;
            out_reg.new_z      <= pz_reg;
            out_reg.collided   <= coll_reg;
            out_reg.table_full <= full_reg;
        end
    end

endmodule

`default_nettype wire

FILE: src/aabb_collision_resolve_unit.sv
// ----------------------------------------------------------------------------
// AABB collision resolve unit
// Obstacle table and point collision response on signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Every request gives exactly one result, in order. A front end registers
// each request and hands it to a two-entry queue, so the input keeps taking
// requests while the back end works and while a result waits on the output,
// until the queue and the front register are full. In the back end, clear
// and append go straight to emit. A resolve runs the border and clamp
// states and then goes to emit when the outer clamp moves the point on x
// or z or the table is empty; otherwise it walks the N stored obstacles:
// it reads the obstacle memory through its single read port, one obstacle
// per cycle, then grows and tests it in two more pipeline stages.
`default_nettype none

module aabb_collision_resolve_unit
    import aabb_pkg::*;
#(
    parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z, obstacle_min_x,
                                                  // obstacle_min_y, obstacle_min_z,
                                                  // obstacle_max_x, obstacle_max_y,
                                                  // obstacle_max_z
    input  wire logic [MODE_W-1:0]     s_tuser,   // mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // new_x, new_y, new_z, collided,
                                                  // table_full, zero fill
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    logic    push_valid;
    logic    push_ready;
    item_t   push_item;
    logic    pop_valid;
    logic    pop_ready;
    item_t   pop_item;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outer.lo_x   <= {1'b1, {(COORD_W-1){1'b0}}};
            cfg_reg.outer.lo_y   <= {1'b1, {(COORD_W-1){1'b0}}};
            cfg_reg.outer.lo_z   <= {1'b1, {(COORD_W-1){1'b0}}};
            cfg_reg.outer.hi_x   <= {1'b0, {(COORD_W-1){1'b1}}};
            cfg_reg.outer.hi_y   <= {1'b0, {(COORD_W-1){1'b1}}};
            cfg_reg.outer.hi_z   <= {1'b0, {(COORD_W-1){1'b1}}};
            cfg_reg.outer_margin <= '0;
            cfg_reg.inner_margin <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUTER_MIN_X:  cfg_reg.outer.lo_x   <= cfg_wdata[COORD_W-1:0];
                REG_OUTER_MIN_Y:  cfg_reg.outer.lo_y   <= cfg_wdata[COORD_W-1:0];
                REG_OUTER_MIN_Z:  cfg_reg.outer.lo_z   <= cfg_wdata[COORD_W-1:0];
                REG_OUTER_MAX_X:  cfg_reg.outer.hi_x   <= cfg_wdata[COORD_W-1:0];
                REG_OUTER_MAX_Y:  cfg_reg.outer.hi_y   <= cfg_wdata[COORD_W-1:0];
                REG_OUTER_MAX_Z:  cfg_reg.outer.hi_z   <= cfg_wdata[COORD_W-1:0];
                REG_OUTER_MARGIN: cfg_reg.outer_margin <= cfg_wdata[MARGIN_W-1:0];
                REG_INNER_MARGIN: cfg_reg.inner_margin <= cfg_wdata[MARGIN_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    aabb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    aabb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    aabb_back #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {{(M_TDATA_W-M_FIELD_W){1'b0}}, result.table_full, result.collided,
                      result.new_z, result.new_y, result.new_x};

endmodule

`default_nettype wire

FILE: src/aabb_chk.sv
// ----------------------------------------------------------------------------
// AABB collision resolve checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aabb_collision_resolve_unit_assert.svh"

module aabb_chk
    import aabb_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic               stalled;
    logic               full_flag;
    logic [3*COORD_W:0] rest_bits;

    assign stalled   = m_tvalid && !m_tready;
    assign full_flag = m_tdata[3*COORD_W+1];
    assign rest_bits = m_tdata[3*COORD_W:0];

    // A stalled result stays on the bus unchanged.
    `AABB_ASSERT(a_out_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // A dropped append reports nothing but the full flag.
    `AABB_ASSERT(a_full_alone, m_tvalid && full_flag |-> rest_bits == '0, "full result not zero")

    // Coming out of reset the output holds no result.
    `AABB_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> !m_tvalid, "result valid after reset")

endmodule

bind aabb_collision_resolve_unit aabb_chk u_chk (.*);

`default_nettype wire
